// File: design/segment_intersection_defines.svh
// assertion macros for the segment intersection block
`ifndef SEGMENT_INTERSECTION_DEFINES_SVH
`define SEGMENT_INTERSECTION_DEFINES_SVH

// same-cycle implication, disabled in reset
`define SI_ASSERT_NOW(label, clk, rst, lhs, rhs, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) else $error(msg);

// next-cycle implication, disabled in reset
`define SI_ASSERT_NEXT(label, clk, rst, lhs, rhs, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) else $error(msg);

`endif

// File: design/si_pkg.sv
// shared types and constants for the segment intersection block
package si_pkg;
   localparam int TQ_FRAC = 32;

   typedef struct packed {
      logic en;
      logic valid;
   } si_ctl_type;
endpackage

// File: design/si_req_if.sv
// request channel carrying two segments
interface si_req_if #(parameter int W = 32);
   logic valid;
   logic ready;
   logic [W-1:0] a_start_x;
   logic [W-1:0] a_start_y;
   logic [W-1:0] a_start_z;
   logic [W-1:0] a_end_x;
   logic [W-1:0] a_end_y;
   logic [W-1:0] a_end_z;
   logic [W-1:0] b_start_x;
   logic [W-1:0] b_start_y;
   logic [W-1:0] b_end_x;
   logic [W-1:0] b_end_y;

   modport source (output valid, a_start_x, a_start_y, a_start_z, a_end_x, a_end_y, a_end_z,
                   b_start_x, b_start_y, b_end_x, b_end_y, input ready);
   modport sink (input valid, a_start_x, a_start_y, a_start_z, a_end_x, a_end_y, a_end_z,
                 b_start_x, b_start_y, b_end_x, b_end_y, output ready);
endinterface

// File: design/si_rsp_if.sv
// response channel carrying the intersection point
interface si_rsp_if #(parameter int W = 32);
   logic valid;
   logic ready;
   logic found;
   logic [W-1:0] cross_x;
   logic [W-1:0] cross_y;
   logic [W-1:0] cross_z;

   modport source (output valid, found, cross_x, cross_y, cross_z, input ready);
   modport sink (input valid, found, cross_x, cross_y, cross_z, output ready);
endinterface

// File: design/si_div.sv
// pipelined restoring divider, one quotient bit per stage, with sideband
module si_div #(
   parameter int NW = 67,
   parameter int SW = 8
) (
   input  logic                   clock,
   input  logic                   reset,
   input  si_pkg::si_ctl_type     ctl,
   input  logic [NW-1:0]          num,
   input  logic [NW-1:0]          den,
   input  logic [SW-1:0]          side,
   output logic                   out_valid,
   output logic [si_pkg::TQ_FRAC-1:0] quo,
   output logic [SW-1:0]          side_out
);
   import si_pkg::*;

   localparam int RW = NW + 1;
   localparam int QW = TQ_FRAC;

   logic [RW-1:0] r_ff [0:QW];
   logic [NW-1:0] d_ff [0:QW];
   logic [QW-1:0] q_ff [0:QW];
   logic [SW-1:0] s_ff [0:QW];
   logic          v_ff [0:QW];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff[0] <= 1'b0;
      end else if (ctl.en) begin
         v_ff[0] <= ctl.valid;
      end
      if (ctl.en) begin
         r_ff[0] <= {1'b0, num};
         d_ff[0] <= den;
         q_ff[0] <= '0;
         s_ff[0] <= side;
      end
   end

   for (genvar k = 0; k < QW; k++) begin : g_stage
      logic [RW-1:0] sh_in;
      logic          ge_in;
      logic [RW-1:0] r_in;

      assign sh_in = {r_ff[k][RW-2:0], 1'b0};
      assign ge_in = sh_in >= {1'b0, d_ff[k]};
      assign r_in  = ge_in ? sh_in - {1'b0, d_ff[k]} : sh_in;

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k+1] <= 1'b0;
         end else if (ctl.en) begin
            v_ff[k+1] <= v_ff[k];
         end
         if (ctl.en) begin
            r_ff[k+1] <= r_in;
            d_ff[k+1] <= d_ff[k];
            q_ff[k+1] <= {q_ff[k][QW-2:0], ge_in};
            s_ff[k+1] <= s_ff[k];
         end
      end
   end

   assign out_valid = v_ff[QW];
   assign quo       = q_ff[QW];
   assign side_out  = s_ff[QW];
endmodule

// File: design/segment_intersection.sv
// segment intersection top level
// Fully pipelined: one segment pair is taken every cycle unless the response channel
// stalls; each result passes through 5 front stages (differences, products, determinant,
// sign normalisation, range checks), 33 divider stages, an input register followed by
// one bit of t per stage, one interpolation multiply stage and the output register.
// Back-pressure on the response channel stalls the whole pipeline in place; nothing
// is dropped.
`include "segment_intersection_defines.svh"
module segment_intersection #(
   parameter int COORD_WIDTH = 32
) (
   input logic  clock,
   input logic  reset,
   si_req_if.sink   req,
   si_rsp_if.source rsp
);
   import si_pkg::*;

   localparam int W  = COORD_WIDTH;
   localparam int DW = 2 * W + 3;
   localparam int PW = 2 * W + 2;
   localparam int TW = TQ_FRAC + 2;
   localparam int MW = TW + W + 1;
   localparam int SW = 2 + 3 * (W + 1) + 3 * W;

   logic en;
   logic rsp_valid_ff;
   si_ctl_type ctl;

   assign en        = !rsp_valid_ff || rsp.ready;
   assign req.ready = en;

   // differences
   logic v1_ff;
   logic signed [W:0] d12x_ff, d12y_ff, d12z_ff, d43x_ff, d43y_ff, d42x_ff, d42y_ff;
   logic [W-1:0] p2x_ff, p2y_ff, p2z_ff;
   // products
   logic v2_ff;
   logic signed [PW-1:0] pa_ff, pb_ff, pc_ff, pd_ff, pe_ff, pf_ff;
   logic signed [W:0] d12x2_ff, d12y2_ff, d12z2_ff;
   logic [W-1:0] p2x2_ff, p2y2_ff, p2z2_ff;
   // determinant and numerators
   logic v3_ff;
   logic signed [DW-1:0] det_ff, tn_ff, sn_ff;
   logic signed [W:0] d12x3_ff, d12y3_ff, d12z3_ff;
   logic [W-1:0] p2x3_ff, p2y3_ff, p2z3_ff;
   // sign normalised
   logic v4_ff, nz4_ff;
   logic signed [DW-1:0] det4_ff, tn4_ff, sn4_ff;
   logic signed [W:0] d12x4_ff, d12y4_ff, d12z4_ff;
   logic [W-1:0] p2x4_ff, p2y4_ff, p2z4_ff;
   // range checked
   logic v5_ff, found5_ff, full5_ff;
   logic [DW-1:0] det5_ff, tn5_ff;
   logic signed [W:0] d12x5_ff, d12y5_ff, d12z5_ff;
   logic [W-1:0] p2x5_ff, p2y5_ff, p2z5_ff;
   // interpolation products
   logic vm_ff, foundm_ff;
   logic signed [MW-1:0] mx_ff, my_ff, mz_ff;
   logic [W-1:0] p2xm_ff, p2ym_ff, p2zm_ff;
   // output
   logic found_ff;
   logic [W-1:0] cx_ff, cy_ff, cz_ff;

   logic found5_in, full5_in;
   logic [TQ_FRAC:0] t_in;

   logic dv;
   logic [TQ_FRAC-1:0] dq;
   logic [SW-1:0] dside;
   logic d_found, d_full;
   logic signed [W:0] dd12x, dd12y, dd12z;
   logic [W-1:0] dp2x, dp2y, dp2z;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         vm_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= req.valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
         vm_ff <= dv;
         rsp_valid_ff <= vm_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         d12x_ff <= $signed({req.a_start_x[W-1], req.a_start_x})
                  - $signed({req.a_end_x[W-1], req.a_end_x});
         d12y_ff <= $signed({req.a_start_y[W-1], req.a_start_y})
                  - $signed({req.a_end_y[W-1], req.a_end_y});
         d12z_ff <= $signed({req.a_start_z[W-1], req.a_start_z})
                  - $signed({req.a_end_z[W-1], req.a_end_z});
         d43x_ff <= $signed({req.b_end_x[W-1], req.b_end_x})
                  - $signed({req.b_start_x[W-1], req.b_start_x});
         d43y_ff <= $signed({req.b_end_y[W-1], req.b_end_y})
                  - $signed({req.b_start_y[W-1], req.b_start_y});
         d42x_ff <= $signed({req.b_end_x[W-1], req.b_end_x})
                  - $signed({req.a_end_x[W-1], req.a_end_x});
         d42y_ff <= $signed({req.b_end_y[W-1], req.b_end_y})
                  - $signed({req.a_end_y[W-1], req.a_end_y});
         p2x_ff <= req.a_end_x;
         p2y_ff <= req.a_end_y;
         p2z_ff <= req.a_end_z;

         pa_ff <= PW'(d12x_ff * d43y_ff);
         pb_ff <= PW'(d43x_ff * d12y_ff);
         pc_ff <= PW'(d43y_ff * d42x_ff);
         pd_ff <= PW'(d43x_ff * d42y_ff);
         pe_ff <= PW'(d12x_ff * d42y_ff);
         pf_ff <= PW'(d12y_ff * d42x_ff);
         d12x2_ff <= d12x_ff;
         d12y2_ff <= d12y_ff;
         d12z2_ff <= d12z_ff;
         p2x2_ff <= p2x_ff;
         p2y2_ff <= p2y_ff;
         p2z2_ff <= p2z_ff;

         det_ff <= DW'(pa_ff) - DW'(pb_ff);
         tn_ff  <= DW'(pc_ff) - DW'(pd_ff);
         sn_ff  <= DW'(pe_ff) - DW'(pf_ff);
         d12x3_ff <= d12x2_ff;
         d12y3_ff <= d12y2_ff;
         d12z3_ff <= d12z2_ff;
         p2x3_ff <= p2x2_ff;
         p2y3_ff <= p2y2_ff;
         p2z3_ff <= p2z2_ff;

         nz4_ff  <= det_ff != '0;
         det4_ff <= det_ff[DW-1] ? -det_ff : det_ff;
         tn4_ff  <= det_ff[DW-1] ? -tn_ff : tn_ff;
         sn4_ff  <= det_ff[DW-1] ? -sn_ff : sn_ff;
         d12x4_ff <= d12x3_ff;
         d12y4_ff <= d12y3_ff;
         d12z4_ff <= d12z3_ff;
         p2x4_ff <= p2x3_ff;
         p2y4_ff <= p2y3_ff;
         p2z4_ff <= p2z3_ff;

         found5_ff <= found5_in;
         full5_ff  <= full5_in;
         det5_ff   <= det4_ff;
         tn5_ff    <= tn4_ff;
         d12x5_ff <= d12x4_ff;
         d12y5_ff <= d12y4_ff;
         d12z5_ff <= d12z4_ff;
         p2x5_ff <= p2x4_ff;
         p2y5_ff <= p2y4_ff;
         p2z5_ff <= p2z4_ff;

         foundm_ff <= d_found;
         mx_ff <= MW'($signed({1'b0, t_in}) * dd12x);
         my_ff <= MW'($signed({1'b0, t_in}) * dd12y);
         mz_ff <= MW'($signed({1'b0, t_in}) * dd12z);
         p2xm_ff <= dp2x;
         p2ym_ff <= dp2y;
         p2zm_ff <= dp2z;

         found_ff <= foundm_ff;
         cx_ff <= foundm_ff ? mx_ff[TQ_FRAC +: W] + p2xm_ff : '0;
         cy_ff <= foundm_ff ? my_ff[TQ_FRAC +: W] + p2ym_ff : '0;
         cz_ff <= foundm_ff ? mz_ff[TQ_FRAC +: W] + p2zm_ff : '0;
      end
   end

   assign found5_in = nz4_ff && !tn4_ff[DW-1] && !sn4_ff[DW-1]
                   && ($unsigned(det4_ff) >= $unsigned(tn4_ff))
                   && ($unsigned(det4_ff) >= $unsigned(sn4_ff));
   assign full5_in  = tn4_ff == det4_ff;

   assign ctl.en    = en;
   assign ctl.valid = v5_ff;

   si_div #(.NW(DW), .SW(SW)) u_div (
      .clock    (clock),
      .reset    (reset),
      .ctl      (ctl),
      .num      (tn5_ff),
      .den      (det5_ff),
      .side     ({found5_ff, full5_ff, d12x5_ff, d12y5_ff, d12z5_ff,
                  p2x5_ff, p2y5_ff, p2z5_ff}),
      .out_valid(dv),
      .quo      (dq),
      .side_out (dside)
   );

   assign {d_found, d_full, dd12x, dd12y, dd12z, dp2x, dp2y, dp2z} = dside;
   assign t_in = d_full ? {1'b1, {TQ_FRAC{1'b0}}} : {1'b0, dq};

   assign rsp.valid   = rsp_valid_ff;
   assign rsp.found   = found_ff;
   assign rsp.cross_x = cx_ff;
   assign rsp.cross_y = cy_ff;
   assign rsp.cross_z = cz_ff;

   `SI_ASSERT_NOW(a_miss_zero, clock, reset, rsp.valid && !rsp.found, rsp.cross_x == '0 && rsp.cross_y == '0 && rsp.cross_z == '0, "miss with nonzero point")
   `SI_ASSERT_NOW(a_ready_free, clock, reset, !rsp_valid_ff, req.ready, "not ready with empty output")
   `SI_ASSERT_NEXT(a_stall_hold, clock, reset, !en, $stable(v5_ff) && $stable(vm_ff), "pipeline moved in stall")
endmodule
